// File: src/gin_pkg.sv
package gin_pkg;

    // Sample and request widths
    localparam int SMP_W  = 16;
    localparam int IN_W   = 8 * SMP_W;
    localparam int DIFF_W = SMP_W + 2;
    localparam int ABS_W  = SMP_W + 1;
    localparam int SQR_W  = 2 * ABS_W;
    localparam int SUM_W  = SQR_W + 1;

    // Square root datapath: both roots run on a 64-bit radicand
    localparam int SQ_W  = 64;
    localparam int SQ1_N = 31;
    localparam int SQ2_N = 32;
    localparam int Z_W   = 32;
    localparam int D_W   = 32;

    localparam logic [SUM_W-1:0] ONE_SQ  = SUM_W'(1) << 32;
    localparam logic [Z_W-1:0]   ONE_Q30 = Z_W'(1) << 30;

    // Per-request sideband carried down the pipeline
    typedef struct packed {
        logic             sx;
        logic             sy;
        logic             inv;
        logic [ABS_W-1:0] ax;
        logic [ABS_W-1:0] ay;
    } t_side;

    typedef struct packed {
        logic sx;
        logic sy;
        logic inv;
    } t_flag;

endpackage

// File: src/gradient_illumination_normal_unit.sv
// Throughput: one request per cycle while the skid stage is empty (s_tready high); the
// two bit-serial square roots and the three restoring dividers are unrolled into one
// register stage per result bit. An output register and a one-entry skid stage let the
// pipeline move on while a result waits to be taken. Synchronous active-low reset
// clears all valid bits, the skid stage and r_cross; payload registers are not reset.
module gradient_illumination_normal_unit
    import gin_pkg::*;
#(
    parameter int FRACTION_BITS = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // par_pos_x, par_neg_x, par_pos_y, par_neg_y, cross_pos_x, cross_neg_x,
    // cross_pos_y, cross_neg_y (16 bits each, lowest first)
    input  logic [IN_W-1:0]     s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // normal_x, normal_y, normal_z (FRACTION_BITS+1 bits each, lowest first), zero fill
    output logic [((3*(FRACTION_BITS+1)+7)/8)*8-1:0] m_tdata,
    // invalid
    output logic                m_tuser
);

    localparam int OUT_W   = FRACTION_BITS + 1;
    localparam int TDATA_W = ((3 * OUT_W + 7) / 8) * 8;
    localparam int QW      = FRACTION_BITS + 2;
    localparam int REM_W   = FRACTION_BITS + 33;
    localparam int DSH_W   = REM_W + 1;
    localparam int RES_W   = 3 * OUT_W + 1;
    localparam logic [QW-1:0] POS_MAX = (QW'(1) << FRACTION_BITS) - QW'(1);
    localparam logic [QW-1:0] NEG_MAG = QW'(1) << FRACTION_BITS;

    logic r_cross;
    logic en;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cross <= 1'b0;
        end else if (i_cfg_we) begin
            r_cross <= i_cfg_wdata;
        end
    end

    // ---------------- Stage 1: differences and magnitudes ----------------
    logic signed [DIFF_W-1:0] w_px, w_nx, w_py, w_ny, w_x, w_y;
    logic        r_s1_vld;
    t_side       r_s1_side;

    always_comb begin
        w_px = DIFF_W'(s_tdata[SMP_W-1:0])
             - (r_cross ? DIFF_W'(s_tdata[5*SMP_W-1:4*SMP_W]) : '0);
        w_nx = DIFF_W'(s_tdata[2*SMP_W-1:SMP_W])
             - (r_cross ? DIFF_W'(s_tdata[6*SMP_W-1:5*SMP_W]) : '0);
        w_py = DIFF_W'(s_tdata[3*SMP_W-1:2*SMP_W])
             - (r_cross ? DIFF_W'(s_tdata[7*SMP_W-1:6*SMP_W]) : '0);
        w_ny = DIFF_W'(s_tdata[4*SMP_W-1:3*SMP_W])
             - (r_cross ? DIFF_W'(s_tdata[8*SMP_W-1:7*SMP_W]) : '0);
        w_x  = w_nx - w_px;
        w_y  = w_py - w_ny;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side.sx  <= w_x[DIFF_W-1];
            r_s1_side.sy  <= w_y[DIFF_W-1];
            r_s1_side.inv <= 1'b0;
            r_s1_side.ax  <= w_x[DIFF_W-1] ? ABS_W'(-w_x) : ABS_W'(w_x);
            r_s1_side.ay  <= w_y[DIFF_W-1] ? ABS_W'(-w_y) : ABS_W'(w_y);
        end
    end

    // ---------------- Stage 2: squares ----------------
    logic             r_s2_vld;
    t_side            r_s2_side;
    logic [SQR_W-1:0] r_s2_xx, r_s2_yy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_side <= r_s1_side;
            r_s2_xx   <= SQR_W'(r_s1_side.ax) * SQR_W'(r_s1_side.ax);
            r_s2_yy   <= SQR_W'(r_s1_side.ay) * SQR_W'(r_s1_side.ay);
        end
    end

    // ---------------- Stage 3: disc test and first radicand ----------------
    logic [SUM_W-1:0] w_s;
    logic             w_inv;

    logic            r_a_vld  [0:SQ1_N];
    t_side           r_a_side [0:SQ1_N];
    logic [SQ_W-1:0] r_a_r    [0:SQ1_N];
    logic [SQ_W-1:0] r_a_v    [0:SQ1_N-1];

    assign w_s   = SUM_W'(r_s2_xx) + SUM_W'(r_s2_yy);
    assign w_inv = w_s > ONE_SQ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld[0] <= 1'b0;
        end else if (en) begin
            r_a_vld[0] <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_side[0] <= '{sx: r_s2_side.sx, sy: r_s2_side.sy, inv: w_inv,
                             ax: r_s2_side.ax, ay: r_s2_side.ay};
            r_a_r[0]    <= '0;
            r_a_v[0]    <= w_inv ? '0 : SQ_W'(ONE_SQ - w_s) << 28;
        end
    end

    // ---------------- First square root: z, one result bit per stage ----------------
    for (genvar j = 0; j < SQ1_N; j++) begin : g_sq1
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ1_N - 1 - j));
        logic [SQ_W-1:0] w_t;
        logic            w_ge;

        assign w_t  = r_a_r[j] + BIT;
        assign w_ge = r_a_v[j] >= w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_a_vld[j+1] <= r_a_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_a_side[j+1] <= r_a_side[j];
                r_a_r[j+1]    <= w_ge ? (r_a_r[j] >> 1) + BIT : r_a_r[j] >> 1;
            end
        end

        if (j < SQ1_N - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_a_v[j+1] <= w_ge ? r_a_v[j] - w_t : r_a_v[j];
                end
            end
        end
    end

    // ---------------- 1 + z and second radicand ----------------
    logic [Z_W-1:0] w_zp1;

    logic            r_b_vld  [0:SQ2_N];
    t_side           r_b_side [0:SQ2_N];
    logic [Z_W-1:0]  r_b_zp1  [0:SQ2_N];
    logic [SQ_W-1:0] r_b_r    [0:SQ2_N];
    logic [SQ_W-1:0] r_b_v    [0:SQ2_N-1];

    assign w_zp1 = Z_W'(r_a_r[SQ1_N][30:0]) + ONE_Q30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld[0] <= 1'b0;
        end else if (en) begin
            r_b_vld[0] <= r_a_vld[SQ1_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_side[0] <= r_a_side[SQ1_N];
            r_b_zp1[0]  <= w_zp1;
            r_b_r[0]    <= '0;
            r_b_v[0]    <= SQ_W'(w_zp1) << 31;
        end
    end

    // ---------------- Second square root: denominator ----------------
    for (genvar j = 0; j < SQ2_N; j++) begin : g_sq2
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ2_N - 1 - j));
        logic [SQ_W-1:0] w_t;
        logic            w_ge;

        assign w_t  = r_b_r[j] + BIT;
        assign w_ge = r_b_v[j] >= w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_b_vld[j+1] <= r_b_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_b_side[j+1] <= r_b_side[j];
                r_b_zp1[j+1]  <= r_b_zp1[j];
                r_b_r[j+1]    <= w_ge ? (r_b_r[j] >> 1) + BIT : r_b_r[j] >> 1;
            end
        end

        if (j < SQ2_N - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_b_v[j+1] <= w_ge ? r_b_v[j] - w_t : r_b_v[j];
                end
            end
        end
    end

    // ---------------- Divider set-up: numerators with half the divisor added ----------------
    logic [D_W-1:0] w_d;
    t_side          w_bs;

    logic             r_c_vld  [0:QW];
    t_flag            r_c_flag [0:QW];
    logic [QW-1:0]    r_c_qx   [0:QW];
    logic [QW-1:0]    r_c_qy   [0:QW];
    logic [QW-1:0]    r_c_qz   [0:QW];
    logic [D_W-1:0]   r_c_d    [0:QW-1];
    logic [REM_W-1:0] r_c_rx   [0:QW-1];
    logic [REM_W-1:0] r_c_ry   [0:QW-1];
    logic [REM_W-1:0] r_c_rz   [0:QW-1];

    assign w_d  = r_b_r[SQ2_N][D_W-1:0];
    assign w_bs = r_b_side[SQ2_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld[0] <= 1'b0;
        end else if (en) begin
            r_c_vld[0] <= r_b_vld[SQ2_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_flag[0] <= '{sx: w_bs.sx, sy: w_bs.sy, inv: w_bs.inv};
            r_c_d[0]    <= w_d;
            r_c_rx[0]   <= (REM_W'(w_bs.ax) << (14 + FRACTION_BITS)) + REM_W'(w_d >> 1);
            r_c_ry[0]   <= (REM_W'(w_bs.ay) << (14 + FRACTION_BITS)) + REM_W'(w_d >> 1);
            r_c_rz[0]   <= (REM_W'(r_b_zp1[SQ2_N]) << FRACTION_BITS) + REM_W'(w_d >> 1);
            r_c_qx[0]   <= '0;
            r_c_qy[0]   <= '0;
            r_c_qz[0]   <= '0;
        end
    end

    // ---------------- Restoring dividers: one quotient bit per stage ----------------
    for (genvar j = 0; j < QW; j++) begin : g_div
        localparam int SH = QW - 1 - j;
        logic [DSH_W-1:0] w_dsh;
        logic             w_gx, w_gy, w_gz;

        assign w_dsh = DSH_W'(r_c_d[j]) << SH;
        assign w_gx  = {1'b0, r_c_rx[j]} >= w_dsh;
        assign w_gy  = {1'b0, r_c_ry[j]} >= w_dsh;
        assign w_gz  = {1'b0, r_c_rz[j]} >= w_dsh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_c_vld[j+1] <= r_c_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_c_flag[j+1] <= r_c_flag[j];
                r_c_qx[j+1]   <= r_c_qx[j] | (QW'(w_gx) << SH);
                r_c_qy[j+1]   <= r_c_qy[j] | (QW'(w_gy) << SH);
                r_c_qz[j+1]   <= r_c_qz[j] | (QW'(w_gz) << SH);
            end
        end

        if (j < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_c_d[j+1]  <= r_c_d[j];
                    r_c_rx[j+1] <= w_gx ? r_c_rx[j] - w_dsh[REM_W-1:0] : r_c_rx[j];
                    r_c_ry[j+1] <= w_gy ? r_c_ry[j] - w_dsh[REM_W-1:0] : r_c_ry[j];
                    r_c_rz[j+1] <= w_gz ? r_c_rz[j] - w_dsh[REM_W-1:0] : r_c_rz[j];
                end
            end
        end
    end

    // ---------------- Sign, saturation and invalid masking ----------------
    function automatic logic [OUT_W-1:0] sat_comp(input logic neg, input logic [QW-1:0] q);
        logic [OUT_W-1:0] r;
        if (!neg) begin
            r = (q > POS_MAX) ? POS_MAX[OUT_W-1:0] : q[OUT_W-1:0];
        end else begin
            r = (q > NEG_MAG) ? NEG_MAG[OUT_W-1:0] : ~q[OUT_W-1:0] + OUT_W'(1);
        end
        return r;
    endfunction

    logic [RES_W-1:0] w_fin;
    t_flag            w_fl;

    assign w_fl  = r_c_flag[QW];
    assign w_fin = w_fl.inv ? {1'b1, {(RES_W-1){1'b0}}}
                 : {1'b0, sat_comp(1'b0, r_c_qz[QW]), sat_comp(w_fl.sy, r_c_qy[QW]),
                    sat_comp(w_fl.sx, r_c_qx[QW])};

    // ---------------- Output register and skid stage ----------------
    logic             r_out_valid, r_skid_valid;
    logic [RES_W-1:0] r_out, r_skid;

    assign en       = !r_skid_valid;
    assign s_tready = en;

    // The pipeline is frozen while the skid stage is full, so its last stage
    // only moves into the skid stage when that stage is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= r_c_vld[QW];
                r_out       <= w_fin;
            end
        end else if (r_c_vld[QW] && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
            r_skid       <= w_fin;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = TDATA_W'(r_out[3*OUT_W-1:0]);
    assign m_tuser  = r_out[RES_W-1];

    // ---------------- Assertions ----------------
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("invalid request carries a non-zero normal");

    a_z_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> !m_tdata[3*OUT_W-1])
        else $error("normal z component is negative");

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a request while the output is empty");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("reset did not clear the output side");

endmodule
